/* rtl/hse_pkg.sv */
// ============================================================================
// Hermite spline evaluator package
// Request codes and field widths shared by the spline evaluator.
// ============================================================================
`default_nettype none

package hse_pkg;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_EVAL  = 1'b1
  } op_e;

  localparam int MaxPoints = 16;
  localparam int CoordW    = 16;
  localparam int IndexW    = 4;
  localparam int TW        = 17;
  localparam int CountW    = 5;
  localparam int InDataW   = 56;
  localparam int OutDataW  = 32;
  localparam logic [TW-1:0] TOne = 17'h10000;

endpackage

`default_nettype wire

/* rtl/hermite_spline_evaluator.sv */
// ============================================================================
// Hermite spline evaluator
// Cubic Hermite spline through a table of 2D control points, fully pipelined.
// ============================================================================
// A write request stores one control point and produces no response; an
// evaluate request returns one position, one request per clock unless the
// output stalls. The rate is set by the six-stage evaluation pipeline, whose
// table lookup uses four copies of the point memory so that all four
// neighbouring points are read in the cycle of acceptance. Stages advance
// independently, so empty stages absorb requests while a response waits at
// the output.
`default_nettype none

module hermite_spline_evaluator #(
  parameter int FRAC_BITS  = 8
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       cfg_we_i,
  input  wire [hse_pkg::CountW-1:0] cfg_wdata_i,     // num_points
  input  wire                       s_axis_tvalid,
  output logic                      s_axis_tready,
  // point_index[3:0], point_x[19:4], point_y[35:20], t_value[52:36], zero pad
  input  wire [hse_pkg::InDataW-1:0] s_axis_tdata,
  input  wire                       s_axis_tuser,    // operation
  output logic                      m_axis_tvalid,
  input  wire                       m_axis_tready,
  output logic [hse_pkg::OutDataW-1:0] m_axis_tdata, // pos_x[15:0], pos_y[31:16]
  output logic                      m_axis_tuser     // status
);
  import hse_pkg::*;

  localparam int AW = (MaxPoints > 1) ? $clog2(MaxPoints) : 1;
  localparam int NegOne = -(1 << FRAC_BITS);
  localparam int RShift = FRAC_BITS + 17;

  // Configuration.
  logic [CountW-1:0] num_points_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_points_q <= '0;
    end else if (cfg_we_i) begin
      num_points_q <= cfg_wdata_i;
    end
  end

  // Pipeline control.
  logic v1_q, v2_q, v3_q, v4_q, v5_q, vo_q;
  logic en1, en2, en3, en4, en5, eno;
  logic acc;
  op_e  op;

  assign eno = !vo_q || m_axis_tready;
  assign en5 = !v5_q || eno;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign s_axis_tready = en1;
  assign acc = s_axis_tvalid && s_axis_tready;
  assign op  = op_e'(s_axis_tuser);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (en1) v1_q <= acc && (op == OP_EVAL);
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
      if (eno) vo_q <= v5_q;
    end
  end

  // Stage 0: segment selection and table addresses.
  logic [IndexW-1:0]        in_idx;
  logic signed [CoordW-1:0] in_x, in_y;
  logic [TW-1:0]            in_t, t_cl;
  logic [CountW-1:0]        n_eff, nm1, seg, addr_a, addr_c, addr_d;
  logic [21:0]              prod;
  logic [TW-1:0]            u0;
  logic                     err0, first0, last0;

  assign in_idx = s_axis_tdata[3:0];
  assign in_x   = s_axis_tdata[19:4];
  assign in_y   = s_axis_tdata[35:20];
  assign in_t   = s_axis_tdata[52:36];

  always_comb begin
    n_eff = (int'(num_points_q) > MaxPoints) ? CountW'(MaxPoints) : num_points_q;
    nm1   = n_eff - 1'b1;
    err0  = (n_eff < 5'd2);
    t_cl  = (in_t > TOne) ? TOne : in_t;
    prod  = 22'(t_cl) * 22'(nm1);
    if (prod[21:16] >= {1'b0, nm1}) begin
      seg = nm1 - 1'b1;
      u0  = TOne;
    end else begin
      seg = prod[20:16];
      u0  = {1'b0, prod[15:0]};
    end
    first0 = (seg == '0);
    last0  = ((seg + 1'b1) == nm1);
    addr_a = first0 ? seg : seg - 1'b1;
    addr_c = seg + 1'b1;
    addr_d = last0 ? addr_c : seg + 5'd2;
  end

  // Point table, four read copies.
  logic [31:0] tbl_a_q [MaxPoints];
  logic [31:0] tbl_b_q [MaxPoints];
  logic [31:0] tbl_c_q [MaxPoints];
  logic [31:0] tbl_d_q [MaxPoints];
  logic [31:0] pa_q, pb_q, pc_q, pd_q;

  always_ff @(posedge clk_i) begin
    if (acc && (op == OP_WRITE) && (int'(in_idx) < MaxPoints)) begin
      tbl_a_q[AW'(in_idx)] <= {in_y, in_x};
      tbl_b_q[AW'(in_idx)] <= {in_y, in_x};
      tbl_c_q[AW'(in_idx)] <= {in_y, in_x};
      tbl_d_q[AW'(in_idx)] <= {in_y, in_x};
    end
    if (en1) begin
      pa_q <= tbl_a_q[AW'(addr_a)];
      pb_q <= tbl_b_q[AW'(seg)];
      pc_q <= tbl_c_q[AW'(addr_c)];
      pd_q <= tbl_d_q[AW'(addr_d)];
    end
  end

  logic              err1_q, first1_q, last1_q;
  logic [CountW-1:0] nm1_1_q;
  logic [TW-1:0]     u1_q;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      err1_q   <= err0;
      first1_q <= first0;
      last1_q  <= last0;
      nm1_1_q  <= nm1;
      u1_q     <= u0;
    end
  end

  // Stage 1: tangents and u squared.
  logic signed [16:0] span_x1, dca_x, ddb_x, dcb_y, dca_y, ddb_y;
  logic signed [22:0] t0x1, t1x1, t0y1, t1y1;
  logic signed [5:0]  nm1_s;
  logic [32:0]        usq1;

  always_comb begin
    nm1_s   = signed'({1'b0, nm1_1_q});
    span_x1 = 17'(signed'(pc_q[15:0])) - 17'(signed'(pb_q[15:0]));
    dca_x   = 17'(signed'(pc_q[15:0])) - 17'(signed'(pa_q[15:0]));
    ddb_x   = 17'(signed'(pd_q[15:0])) - 17'(signed'(pb_q[15:0]));
    dcb_y   = 17'(signed'(pc_q[31:16])) - 17'(signed'(pb_q[31:16]));
    dca_y   = 17'(signed'(pc_q[31:16])) - 17'(signed'(pa_q[31:16]));
    ddb_y   = 17'(signed'(pd_q[31:16])) - 17'(signed'(pb_q[31:16]));
    t0x1 = first1_q ? 23'(span_x1) <<< 1 : 23'(dca_x) * 23'(nm1_s);
    t1x1 = last1_q  ? 23'(span_x1) <<< 1 : 23'(ddb_x) * 23'(nm1_s);
    t0y1 = first1_q ? 23'(dcb_y) <<< 1   : 23'(dca_y) * 23'(nm1_s);
    t1y1 = last1_q  ? 23'(dcb_y) <<< 1   : 23'(ddb_y) * 23'(nm1_s);
    usq1 = 33'(34'(u1_q) * 34'(u1_q));
  end

  logic                     err2_q;
  logic [TW-1:0]            u2_q;
  logic [32:0]              usq2_q;
  logic signed [16:0]       span2_q;
  logic signed [22:0]       t0x2_q, t1x2_q, t0y2_q, t1y2_q;
  logic signed [CoordW-1:0] bx2_q, by2_q, cx2_q, cy2_q;

  always_ff @(posedge clk_i) begin
    if (en2) begin
      err2_q  <= err1_q;
      u2_q    <= u1_q;
      usq2_q  <= usq1;
      span2_q <= span_x1;
      t0x2_q  <= t0x1;
      t1x2_q  <= t1x1;
      t0y2_q  <= t0y1;
      t1y2_q  <= t1y1;
      bx2_q   <= pb_q[15:0];
      by2_q   <= pb_q[31:16];
      cx2_q   <= pc_q[15:0];
      cy2_q   <= pc_q[31:16];
    end
  end

  // Stage 2: u cubed and span-scaled tangents.
  logic [48:0]        ucube2;
  logic signed [39:0] st0x2, st1x2, st0y2, st1y2;

  always_comb begin
    ucube2 = 49'(50'(usq2_q) * 50'(u2_q));
    st0x2  = 40'(span2_q) * 40'(t0x2_q);
    st1x2  = 40'(span2_q) * 40'(t1x2_q);
    st0y2  = 40'(span2_q) * 40'(t0y2_q);
    st1y2  = 40'(span2_q) * 40'(t1y2_q);
  end

  logic                     err3_q;
  logic [TW-1:0]            u3_q;
  logic [32:0]              usq3_q;
  logic [48:0]              ucube3_q;
  logic signed [39:0]       st0x3_q, st1x3_q, st0y3_q, st1y3_q;
  logic signed [CoordW-1:0] bx3_q, by3_q, cx3_q, cy3_q;

  always_ff @(posedge clk_i) begin
    if (en3) begin
      err3_q   <= err2_q;
      u3_q     <= u2_q;
      usq3_q   <= usq2_q;
      ucube3_q <= ucube2;
      st0x3_q  <= st0x2;
      st1x3_q  <= st1x2;
      st0y3_q  <= st0y2;
      st1y3_q  <= st1y2;
      bx3_q    <= bx2_q;
      by3_q    <= by2_q;
      cx3_q    <= cx2_q;
      cy3_q    <= cy2_q;
    end
  end

  // Stage 3: basis weights in signed Q1.16, rounded half up.
  logic signed [51:0] su3, su2s, sus, h00v, h10v, h01v, h11v;
  logic signed [17:0] h00_3, h10_3, h01_3, h11_3;
  localparam logic signed [51:0] HalfLsb = 52'sd1 <<< 31;
  localparam logic signed [51:0] OneQ48  = 52'sd1 <<< 48;

  always_comb begin
    su3   = signed'(52'(ucube3_q));
    su2s  = signed'(52'(usq3_q)) <<< 16;
    sus   = signed'(52'(u3_q)) <<< 32;
    h00v  = (su3 <<< 1) - (su2s * 52'sd3) + OneQ48;
    h10v  = su3 - (su2s <<< 1) + sus;
    h01v  = (su2s * 52'sd3) - (su3 <<< 1);
    h11v  = su3 - su2s;
    h00_3 = 18'((h00v + HalfLsb) >>> 32);
    h10_3 = 18'((h10v + HalfLsb) >>> 32);
    h01_3 = 18'((h01v + HalfLsb) >>> 32);
    h11_3 = 18'((h11v + HalfLsb) >>> 32);
  end

  logic                     err4_q;
  logic signed [17:0]       h00_q, h10_q, h01_q, h11_q;
  logic signed [39:0]       st0x4_q, st1x4_q, st0y4_q, st1y4_q;
  logic signed [CoordW-1:0] bx4_q, by4_q, cx4_q, cy4_q;

  always_ff @(posedge clk_i) begin
    if (en4) begin
      err4_q  <= err3_q;
      h00_q   <= h00_3;
      h10_q   <= h10_3;
      h01_q   <= h01_3;
      h11_q   <= h11_3;
      st0x4_q <= st0x3_q;
      st1x4_q <= st1x3_q;
      st0y4_q <= st0y3_q;
      st1y4_q <= st1y3_q;
      bx4_q   <= bx3_q;
      by4_q   <= by3_q;
      cx4_q   <= cx3_q;
      cy4_q   <= cy3_q;
    end
  end

  // Stage 4: weighted terms.
  logic                err5_q;
  logic signed [33:0]  mbx_q, mcx_q, mby_q, mcy_q;
  logic signed [57:0]  m0x_q, m1x_q, m0y_q, m1y_q;

  always_ff @(posedge clk_i) begin
    if (en5) begin
      err5_q <= err4_q;
      mbx_q  <= 34'(h00_q) * 34'(bx4_q);
      mcx_q  <= 34'(h01_q) * 34'(cx4_q);
      mby_q  <= 34'(h00_q) * 34'(by4_q);
      mcy_q  <= 34'(h01_q) * 34'(cy4_q);
      m0x_q  <= 58'(h10_q) * 58'(st0x4_q);
      m1x_q  <= 58'(h11_q) * 58'(st1x4_q);
      m0y_q  <= 58'(h10_q) * 58'(st0y4_q);
      m1y_q  <= 58'(h11_q) * 58'(st1y4_q);
    end
  end

  // Stage 5: sum, round, saturate.
  localparam logic signed [63:0] RoundBias = 64'sd1 <<< (RShift - 1);
  logic signed [63:0] sum_x, sum_y, rnd_x, rnd_y;
  logic signed [15:0] sat_x, sat_y;

  always_comb begin
    sum_x = ((64'(mbx_q) + 64'(mcx_q)) <<< (FRAC_BITS + 1)) + 64'(m0x_q) + 64'(m1x_q);
    sum_y = ((64'(mby_q) + 64'(mcy_q)) <<< (FRAC_BITS + 1)) + 64'(m0y_q) + 64'(m1y_q);
    rnd_x = (sum_x + RoundBias) >>> RShift;
    rnd_y = (sum_y + RoundBias) >>> RShift;
    if (rnd_x > 64'sd32767) begin
      sat_x = 16'sh7fff;
    end else if (rnd_x < -64'sd32768) begin
      sat_x = 16'sh8000;
    end else begin
      sat_x = 16'(rnd_x);
    end
    if (rnd_y > 64'sd32767) begin
      sat_y = 16'sh7fff;
    end else if (rnd_y < -64'sd32768) begin
      sat_y = 16'sh8000;
    end else begin
      sat_y = 16'(rnd_y);
    end
  end

  logic [OutDataW-1:0] out_data_q;
  logic                out_err_q;

  always_ff @(posedge clk_i) begin
    if (eno) begin
      out_err_q  <= err5_q;
      out_data_q <= err5_q ? {16'(NegOne), 16'(NegOne)} : {sat_y, sat_x};
    end
  end

  assign m_axis_tvalid = vo_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_err_q;

endmodule

`default_nettype wire
